/* sv/svpj_pkg.sv */
// Shared types, constants and helpers for the servo pulse generator.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package svpj_pkg;

    localparam int W_FUNC = 2;
    localparam int W_JOY  = 12;
    localparam int W_ANG  = 8;
    localparam int W_PW   = 15;
    localparam int W_CNT  = 15;
    localparam int W_DZ   = 11;
    localparam int W_Q    = 16;
    localparam int W_PROD = W_ANG + W_PW;
    localparam int W_CFG  = 15;
    localparam int W_IDX  = 3;

    localparam int PERIOD_US_DEF = 20000;
    localparam int AUTO_STEP_DEF = 1;

    // Function codes of an input word
    localparam logic [W_FUNC-1:0] FUNC_TICK  = 2'd0;
    localparam logic [W_FUNC-1:0] FUNC_JOY   = 2'd1;
    localparam logic [W_FUNC-1:0] FUNC_ANGLE = 2'd2;

    // Register indexes
    localparam logic [W_IDX-1:0] CFG_MODE    = 3'd0;
    localparam logic [W_IDX-1:0] CFG_MIN_PW  = 3'd1;
    localparam logic [W_IDX-1:0] CFG_MAX_PW  = 3'd2;
    localparam logic [W_IDX-1:0] CFG_ANG_MIN = 3'd3;
    localparam logic [W_IDX-1:0] CFG_ANG_MAX = 3'd4;
    localparam logic [W_IDX-1:0] CFG_CENTER  = 3'd5;
    localparam logic [W_IDX-1:0] CFG_DZ      = 3'd6;
    localparam logic [W_IDX-1:0] CFG_PPS     = 3'd7;

    localparam logic [W_PW-1:0] PW_RESET  = 15'd500;
    localparam logic [W_PW-1:0] PW_MAX    = 15'h7FFF;
    localparam int              JOY_STEP  = 400;
    localparam int              ANG_SPAN  = 180;

    // floor(x / 180) = (x * RECIP) >> RECIP_SHIFT, exact for x below 2^31 / 52
    localparam int              RECIP_SHIFT = 31;
    localparam logic [32:0]     RECIP_NUM   = (33'd1 << RECIP_SHIFT) + 33'(ANG_SPAN - 1);
    localparam logic [23:0]     RECIP       = 24'(RECIP_NUM / 33'(ANG_SPAN));

    typedef struct packed {
        logic              mode;
        logic [W_PW-1:0]   min_pulse;
        logic [W_PW-1:0]   max_pulse;
        logic [W_ANG-1:0]  angle_min;
        logic [W_ANG-1:0]  angle_max;
        logic [W_JOY-1:0]  joy_center;
        logic [W_DZ-1:0]   dead_zone;
        logic [W_ANG-1:0]  pps;
    } t_cfg;

    // Word travelling down the width pipeline
    typedef struct packed {
        logic              tick;
        logic              pstart;
        logic              chg;
        logic [W_ANG-1:0]  ang;
        logic [W_CNT-1:0]  cnt;
    } t_ctl;

    // |dev| / 400 for a 12-bit magnitude
    function automatic logic [3:0] div_joy(input logic [W_JOY-1:0] mag);
        logic [3:0] q;
        q = '0;
        for (int k = 1; k <= 10; k++) begin
            if (mag >= W_JOY'(k * JOY_STEP)) q = q + 4'd1;
        end
        return q;
    endfunction

    // Clamp to angle_max first, then angle_min, so angle_min wins
    function automatic logic [W_ANG-1:0] clamp_angle(input logic signed [9:0] a,
                                                     input logic [W_ANG-1:0] lo,
                                                     input logic [W_ANG-1:0] hi);
        logic signed [9:0] t;
        t = a;
        if (t > $signed({2'b00, hi})) t = $signed({2'b00, hi});
        if (t < $signed({2'b00, lo})) t = $signed({2'b00, lo});
        return t[W_ANG-1:0];
    endfunction

endpackage

`default_nettype wire

/* sv/svpj_in_if.sv */
// Input channel: valid/ready handshake carrying one command word.
// Depends on svpj_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface svpj_in_if import svpj_pkg::*;;
    logic              valid;
    logic              ready;
    logic [W_FUNC-1:0] func;
    logic [W_JOY-1:0]  joystick;
    logic [W_ANG-1:0]  angle_request;

    modport source (output valid, output func, output joystick, output angle_request,
                    input ready);
    modport sink   (input valid, input func, input joystick, input angle_request,
                    output ready);
endinterface

`default_nettype wire

/* sv/svpj_out_if.sv */
// Output channel: valid/ready handshake carrying one status word.
// Depends on svpj_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface svpj_out_if import svpj_pkg::*;;
    logic             valid;
    logic             ready;
    logic             pwm_out;
    logic [W_ANG-1:0] angle;
    logic [W_PW-1:0]  pulse_width_us;
    logic             period_start;

    modport source (output valid, output pwm_out, output angle, output pulse_width_us,
                    output period_start, input ready);
    modport sink   (input valid, input pwm_out, input angle, input pulse_width_us,
                    input period_start, output ready);
endinterface

`default_nettype wire

/* sv/svpj_ctrl.sv */
// Input register and angle control: microsecond counter, sweep and joystick steps.
// Depends on svpj_pkg and svpj_in_if.
`timescale 1ns / 1ps
`default_nettype none

module svpj_ctrl import svpj_pkg::*; #(
    parameter int PERIOD_US = PERIOD_US_DEF,
    parameter int AUTO_STEP = AUTO_STEP_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    svpj_in_if.sink i_in,
    input  t_cfg    i_cfg,
    input  logic    i_sweep_rst,
    input  logic    i_down_rdy,
    output logic    o_vld,
    output t_ctl    o_ctl
);

    localparam logic [W_CNT:0]     CNT_WRAP = (W_CNT + 1)'(PERIOD_US);
    localparam logic signed [9:0]  STEP10   = 10'(AUTO_STEP);

    logic              r_in_vld;
    logic [W_FUNC-1:0] r_func;
    logic [W_JOY-1:0]  r_joy;
    logic [W_ANG-1:0]  r_req;

    logic [W_ANG-1:0]  r_ang, n_ang;
    logic              r_up, n_up;
    logic [W_ANG-1:0]  r_pc, n_pc;
    logic [W_CNT-1:0]  r_cnt, n_cnt;
    logic              n_chg, n_pstart;

    logic              r_vld;
    t_ctl              r_ctl;

    logic              s1_rdy, adv;
    logic [W_CNT:0]    cnt_inc;
    logic [W_ANG-1:0]  pc_inc;
    logic signed [9:0] a10, sweep_nv, jstep, amin10, amax10;
    logic signed [12:0] dev, dz;
    logic [W_JOY-1:0]  mag;

    assign s1_rdy     = !r_vld || i_down_rdy;
    assign adv        = r_in_vld && s1_rdy;
    assign i_in.ready = !r_in_vld || s1_rdy;
    assign o_vld      = r_vld;
    assign o_ctl      = r_ctl;

    always_comb begin
        n_ang    = r_ang;
        n_up     = r_up;
        n_pc     = r_pc;
        n_cnt    = r_cnt;
        n_chg    = 1'b0;
        n_pstart = 1'b0;
        cnt_inc  = {1'b0, r_cnt} + (W_CNT + 1)'(1);
        pc_inc   = r_pc + 8'd1;
        a10      = $signed({2'b00, r_ang});
        amin10   = $signed({2'b00, i_cfg.angle_min});
        amax10   = $signed({2'b00, i_cfg.angle_max});
        sweep_nv = r_up ? a10 + STEP10 : a10 - STEP10;
        dev      = $signed({1'b0, r_joy}) - $signed({1'b0, i_cfg.joy_center});
        dz       = $signed({2'b00, i_cfg.dead_zone});
        mag      = dev[12] ? W_JOY'(-dev) : dev[W_JOY-1:0];
        jstep    = $signed({6'd0, div_joy(mag)}) + 10'sd1;

        case (r_func)
            FUNC_TICK: begin
                if (r_cnt == '0) begin
                    n_pstart = 1'b1;
                    if (!i_cfg.mode) begin
                        if (pc_inc >= i_cfg.pps) begin
                            n_pc  = '0;
                            n_chg = 1'b1;
                            // bounce off the limits
                            if (sweep_nv >= amax10) begin
                                n_ang = i_cfg.angle_max;
                                n_up  = 1'b0;
                            end else if (sweep_nv <= amin10) begin
                                n_ang = i_cfg.angle_min;
                                n_up  = 1'b1;
                            end else begin
                                n_ang = sweep_nv[W_ANG-1:0];
                            end
                        end else begin
                            n_pc = pc_inc;
                        end
                    end
                end
                n_cnt = (cnt_inc >= CNT_WRAP) ? '0 : cnt_inc[W_CNT-1:0];
            end
            FUNC_JOY: begin
                if (i_cfg.mode) begin
                    if (dev > dz) begin
                        n_ang = clamp_angle(a10 + jstep, i_cfg.angle_min, i_cfg.angle_max);
                        n_chg = 1'b1;
                    end else if (dev < -dz) begin
                        n_ang = clamp_angle(a10 - jstep, i_cfg.angle_min, i_cfg.angle_max);
                        n_chg = 1'b1;
                    end
                end
            end
            FUNC_ANGLE: begin
                n_ang = clamp_angle($signed({2'b00, r_req}), i_cfg.angle_min,
                                    i_cfg.angle_max);
                n_chg = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_vld    <= 1'b0;
            r_ang    <= '0;
            r_up     <= 1'b1;
            r_pc     <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_in.ready) r_in_vld <= i_in.valid;
            if (s1_rdy) r_vld <= r_in_vld;
            if (adv) begin
                r_ang <= n_ang;
                r_pc  <= n_pc;
                r_cnt <= n_cnt;
            end
            // writing automatic mode restarts the sweep upward
            if (i_sweep_rst) begin
                r_up <= 1'b1;
            end else if (adv) begin
                r_up <= n_up;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_func <= i_in.func;
            r_joy  <= i_in.joystick;
            r_req  <= i_in.angle_request;
        end
        if (adv) begin
            r_ctl.tick   <= (r_func == FUNC_TICK);
            r_ctl.pstart <= n_pstart;
            r_ctl.chg    <= n_chg;
            r_ctl.ang    <= n_ang;
            r_ctl.cnt    <= r_cnt;
        end
    end

endmodule

`default_nettype wire

/* sv/svpj_scale.sv */
// Angle-to-width scaling: angle * |max - min| / 180 in two multiply stages.
// Depends on svpj_pkg.
`timescale 1ns / 1ps
`default_nettype none

module svpj_scale import svpj_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  t_ctl            i_ctl,
    input  t_cfg            i_cfg,
    input  logic            i_down_rdy,
    output logic            o_rdy,
    output logic            o_vld,
    output t_ctl            o_ctl,
    output logic [W_Q-1:0]  o_q
);

    localparam int W_WIDE = W_PROD + 24;

    logic               r_vld2, r_vld3;
    t_ctl               r_ctl2, r_ctl3;
    logic [W_PROD-1:0]  r_prod;
    logic [W_Q-1:0]     r_q;
    logic               s2_rdy, s3_rdy;
    logic [W_PW-1:0]    diff;
    logic [W_WIDE-1:0]  wide;

    assign s3_rdy = !r_vld3 || i_down_rdy;
    assign s2_rdy = !r_vld2 || s3_rdy;
    assign o_rdy  = s2_rdy;
    assign o_vld  = r_vld3;
    assign o_ctl  = r_ctl3;
    assign o_q    = r_q;

    assign diff = (i_cfg.max_pulse >= i_cfg.min_pulse) ? i_cfg.max_pulse - i_cfg.min_pulse
                                                       : i_cfg.min_pulse - i_cfg.max_pulse;
    // divide by 180 via reciprocal
    assign wide = {24'd0, r_prod} * {W_PROD'(0), RECIP};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            if (s2_rdy) r_vld2 <= i_vld;
            if (s3_rdy) r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld && s2_rdy) begin
            r_ctl2 <= i_ctl;
            r_prod <= {W_PW'(0), i_ctl.ang} * {W_ANG'(0), diff};
        end
        if (r_vld2 && s3_rdy) begin
            r_ctl3 <= r_ctl2;
            r_q    <= wide[RECIP_SHIFT +: W_Q];
        end
    end

endmodule

`default_nettype wire

/* sv/svpj_pin.sv */
// Width finish, pin level and result register feeding the output channel.
// Depends on svpj_pkg and svpj_out_if.
`timescale 1ns / 1ps
`default_nettype none

module svpj_pin import svpj_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  t_ctl              i_ctl,
    input  logic [W_Q-1:0]    i_q,
    input  t_cfg              i_cfg,
    output logic              o_rdy,
    svpj_out_if.source        o_out
);

    logic              r_vld;
    logic              r_pin, n_pin;
    logic [W_PW-1:0]   r_pw, n_pw;
    logic [W_ANG-1:0]  r_ang;
    logic              r_pstart;
    logic              take;
    logic [W_PW+1:0]   sum;
    logic [W_PW+1:0]   dif;
    logic [W_PW-1:0]   w_new;

    assign o_rdy = !r_vld || o_out.ready;
    assign take  = i_vld && o_rdy;

    assign o_out.valid          = r_vld;
    assign o_out.pwm_out        = r_pin;
    assign o_out.angle          = r_ang;
    assign o_out.pulse_width_us = r_pw;
    assign o_out.period_start   = r_pstart;

    always_comb begin
        sum = {2'b00, i_cfg.min_pulse} + {1'b0, i_q};
        dif = {2'b00, i_cfg.min_pulse} - {1'b0, i_q};
        // saturate to the 15-bit range
        if (i_cfg.max_pulse >= i_cfg.min_pulse) begin
            w_new = (sum[W_PW+1] || sum[W_PW]) ? PW_MAX : sum[W_PW-1:0];
        end else begin
            w_new = dif[W_PW+1] ? '0 : dif[W_PW-1:0];
        end
        n_pw  = i_ctl.chg ? w_new : r_pw;
        n_pin = r_pin;
        if (i_ctl.tick) begin
            if (i_ctl.cnt == '0) n_pin = 1'b0;
            if (i_ctl.cnt == n_pw) n_pin = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_pin <= 1'b1;
            r_pw  <= PW_RESET;
        end else begin
            if (o_rdy) r_vld <= i_vld;
            if (take) begin
                r_pin <= n_pin;
                r_pw  <= n_pw;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_ang    <= i_ctl.ang;
            r_pstart <= i_ctl.pstart;
        end
    end

endmodule

`default_nettype wire

/* sv/servo_pwm_sweep_joystick.sv */
// Top level of the RC servo pulse generator: register file and pipeline wiring.
// Depends on svpj_pkg, svpj_in_if, svpj_out_if, svpj_ctrl, svpj_scale, svpj_pin.
`timescale 1ns / 1ps
`default_nettype none

// Each input word is a 1 us tick, a joystick sample or an angle write, and each
// produces exactly one status word (pin level, angle, pulse width, period start).
// The block takes one word per clock and runs a five-register pipeline: input
// register, angle/counter update, angle * span multiply, reciprocal multiply for
// the divide by 180, then width finish with the pin update in the result register.
// The sustained rate is one word per cycle with the output side ready. Write the
// registers only while no words are in flight; a changed width range applies at
// the next angle change.
module servo_pwm_sweep_joystick import svpj_pkg::*; #(
    parameter int PERIOD_US = PERIOD_US_DEF,
    parameter int AUTO_STEP = AUTO_STEP_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [W_IDX-1:0]  i_cfg_idx,
    input  logic [W_CFG-1:0]  i_cfg_data,
    svpj_in_if.sink           i_in,
    svpj_out_if.source        o_out
);

    t_cfg            r_cfg;
    logic            sweep_rst;
    logic            ctl_vld, scl_vld, scl_rdy, pin_rdy;
    t_ctl            ctl_word, scl_word;
    logic [W_Q-1:0]  scl_q;

    assign sweep_rst = i_cfg_we && (i_cfg_idx == CFG_MODE) && !i_cfg_data[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode       <= 1'b0;
            r_cfg.min_pulse  <= 15'd500;
            r_cfg.max_pulse  <= 15'd2500;
            r_cfg.angle_min  <= 8'd0;
            r_cfg.angle_max  <= 8'd180;
            r_cfg.joy_center <= 12'd2048;
            r_cfg.dead_zone  <= 11'd200;
            r_cfg.pps        <= 8'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE:    r_cfg.mode       <= i_cfg_data[0];
                CFG_MIN_PW:  r_cfg.min_pulse  <= i_cfg_data[W_PW-1:0];
                CFG_MAX_PW:  r_cfg.max_pulse  <= i_cfg_data[W_PW-1:0];
                CFG_ANG_MIN: r_cfg.angle_min  <= i_cfg_data[W_ANG-1:0];
                CFG_ANG_MAX: r_cfg.angle_max  <= i_cfg_data[W_ANG-1:0];
                CFG_CENTER:  r_cfg.joy_center <= i_cfg_data[W_JOY-1:0];
                CFG_DZ:      r_cfg.dead_zone  <= i_cfg_data[W_DZ-1:0];
                CFG_PPS:     r_cfg.pps        <= i_cfg_data[W_ANG-1:0];
                default: begin
                end
            endcase
        end
    end

    svpj_ctrl #(
        .PERIOD_US (PERIOD_US),
        .AUTO_STEP (AUTO_STEP)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (r_cfg),
        .i_sweep_rst (sweep_rst),
        .i_down_rdy  (scl_rdy),
        .o_vld       (ctl_vld),
        .o_ctl       (ctl_word)
    );

    svpj_scale u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (ctl_vld),
        .i_ctl      (ctl_word),
        .i_cfg      (r_cfg),
        .i_down_rdy (pin_rdy),
        .o_rdy      (scl_rdy),
        .o_vld      (scl_vld),
        .o_ctl      (scl_word),
        .o_q        (scl_q)
    );

    svpj_pin u_pin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (scl_vld),
        .i_ctl   (scl_word),
        .i_q     (scl_q),
        .i_cfg   (r_cfg),
        .o_rdy   (pin_rdy),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
